FILE: design/fbpa_pkg.sv
// package: payload structs, status and command codes, register indexes, controller states
`default_nettype none

package fbpa_pkg;

   localparam int unsigned FREE_W  = 9;
   localparam int unsigned GIDX_W  = 8;
   localparam int unsigned ADDR_W  = 32;
   localparam int unsigned SIZE_W  = 16;
   localparam int unsigned CSR_AW  = 4;

   localparam logic CMD_ALLOC   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_ALL_FREE = 2'd2;
   localparam logic [1:0] ST_BAD_IDX  = 2'd3;

   localparam logic [1:0] REG_BASE  = 2'd0;
   localparam logic [1:0] REG_SIZE  = 2'd1;
   localparam logic [1:0] REG_COUNT = 2'd2;

   localparam logic [ADDR_W-1:0] BASE_RESET  = 32'd0;
   localparam logic [SIZE_W-1:0] SIZE_RESET  = 16'd64;
   localparam logic [FREE_W-1:0] COUNT_RESET = 9'd256;

   typedef struct packed {
      logic       command;
      logic [7:0] block_index;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [GIDX_W-1:0] granted_index;
      logic [ADDR_W-1:0] granted_address;
      logic [FREE_W-1:0] free_blocks;
   } rsp_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_POP,
      S_HOLD
   } state_type;

endpackage

`default_nettype wire

FILE: design/fixed_block_pool_allocator.sv
// top level: free-list block pool with link memory, clearing pass and csr port
// results: a release or an empty allocate is registered at the accept edge, or kept in
// S_HOLD while the result slot is full; a granting allocate is registered from S_POP.
// throughput: one release per cycle while the result slot is free; no request is taken in
// S_POP, where the head's link is read. Reset and every pool register write start a clearing
// pass over all link entries that rebuilds the link memory; req_ready stays low during it.
`default_nettype none

module fixed_block_pool_allocator
   import fbpa_pkg::*;
#(
   parameter int unsigned MAX_BLOCKS = 256
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire req_type             req_item,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output rsp_type                  rsp_item,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [CSR_AW-1:0]   paddr,
   input  wire logic [31:0]         pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);

   localparam int unsigned IDX_W  = $clog2(MAX_BLOCKS);
   localparam int unsigned LINK_W = $clog2(MAX_BLOCKS + 1);
   localparam int unsigned CMP_W  = (LINK_W > FREE_W) ? LINK_W : FREE_W;
   localparam int unsigned PROD_W = IDX_W + SIZE_W;
   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_BLOCKS);
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(MAX_BLOCKS - 1);

   // configuration registers
   logic [ADDR_W-1:0] base_ff;
   logic [SIZE_W-1:0] size_ff;
   logic [FREE_W-1:0] count_cfg_ff;

   // control and pool state
   state_type         state_ff, state_in;
   logic [LINK_W-1:0] head_ff;
   logic [LINK_W-1:0] free_ff;
   logic [IDX_W-1:0]  clr_ff;
   logic [IDX_W-1:0]  gidx_ff;
   logic [PROD_W-1:0] prod_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_item_ff;
   rsp_type           hold_ff;

   // link memory
   logic [LINK_W-1:0] link_mem [MAX_BLOCKS];
   logic [LINK_W-1:0] rd_ff;

   logic              mem_we;
   logic [IDX_W-1:0]  mem_wa;
   logic [LINK_W-1:0] mem_wd;
   logic              res_load;
   rsp_type           res_data;
   logic              pop_start;
   logic              pop_done;
   logic              push_ok;

   logic              cfg_we;
   logic              accept;
   logic              slot_free;
   logic [CMP_W-1:0]  eff_wide;
   logic [CMP_W-1:0]  bc_wide;
   logic [LINK_W-1:0] eff_count;
   logic              head_ok;
   logic [IDX_W-1:0]  head_idx;
   logic [CMP_W-1:0]  rel_idx_wide;
   logic [LINK_W-1:0] clr_next;
   logic              clr_last;

   assign cfg_we    = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign bc_wide   = CMP_W'(count_cfg_ff);
   assign eff_wide  = (bc_wide > CMP_W'(MAX_BLOCKS)) ? CMP_W'(MAX_BLOCKS) : bc_wide;
   assign eff_count = LINK_W'(eff_wide);

   assign head_ok      = (free_ff != '0) && (head_ff < NULL_LINK);
   assign head_idx     = IDX_W'(head_ff);
   assign rel_idx_wide = CMP_W'(req_item.block_index);
   assign clr_next     = LINK_W'(clr_ff) + LINK_W'(1);
   assign clr_last     = (clr_ff == LAST_IDX);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (req_item.command == CMD_ALLOC && head_ok) begin
                  state_in = S_POP;
               end else if (!slot_free) begin
                  state_in = S_HOLD;
               end
            end
         end
         S_POP: begin
            state_in = slot_free ? S_IDLE : S_HOLD;
         end
         S_HOLD: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
      if (cfg_we && paddr[CSR_AW-1:2] <= REG_COUNT) begin
         state_in = S_CLEAR;
      end
   end

   // outputs of the controller
   always_comb begin
      req_ready = 1'b0;
      mem_we    = 1'b0;
      mem_wa    = clr_ff;
      mem_wd    = NULL_LINK;
      res_load  = 1'b0;
      res_data  = '0;
      pop_start = 1'b0;
      pop_done  = 1'b0;
      push_ok   = 1'b0;
      res_data.free_blocks = FREE_W'(CMP_W'(free_ff));
      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = (clr_next < eff_count) ? clr_next : NULL_LINK;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               if (req_item.command == CMD_ALLOC) begin
                  if (head_ok) begin
                     pop_start = 1'b1;
                  end else begin
                     res_load        = 1'b1;
                     res_data.status = ST_EMPTY;
                  end
               end else begin
                  res_load = 1'b1;
                  if (rel_idx_wide >= eff_wide) begin
                     res_data.status = ST_BAD_IDX;
                  end else if (free_ff >= eff_count) begin
                     res_data.status = ST_ALL_FREE;
                  end else begin
                     push_ok              = 1'b1;
                     mem_we               = 1'b1;
                     mem_wa               = IDX_W'(req_item.block_index);
                     mem_wd               = head_ff;
                     res_data.status      = ST_OK;
                     res_data.free_blocks = FREE_W'(CMP_W'(free_ff + LINK_W'(1)));
                  end
               end
            end
         end
         S_POP: begin
            pop_done                 = 1'b1;
            res_load                 = 1'b1;
            res_data.status          = ST_OK;
            res_data.granted_index   = GIDX_W'(gidx_ff);
            res_data.granted_address = base_ff + ADDR_W'(prod_ff);
            res_data.free_blocks     = FREE_W'(CMP_W'(free_ff - LINK_W'(1)));
         end
         default: begin
         end
      endcase
   end

   // link memory, read data registered
   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_wa] <= mem_wd;
      end
      rd_ff <= link_mem[head_idx];
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (pop_start) begin
         gidx_ff <= head_idx;
         prod_ff <= PROD_W'(head_idx) * PROD_W'(size_ff);
      end
      if (res_load && !slot_free) begin
         hold_ff <= res_data;
      end
      if (res_load && slot_free) begin
         rsp_item_ff <= res_data;
      end else if (state_ff == S_HOLD && slot_free) begin
         rsp_item_ff <= hold_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         head_ff      <= '0;
         free_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= BASE_RESET;
         size_ff      <= SIZE_RESET;
         count_cfg_ff <= COUNT_RESET;
      end else begin
         state_ff <= state_in;

         if (state_ff == S_CLEAR) begin
            clr_ff <= clr_ff + IDX_W'(1);
            if (clr_last) begin
               head_ff <= (eff_count != '0) ? '0 : NULL_LINK;
               free_ff <= eff_count;
            end
         end
         if (push_ok) begin
            head_ff <= LINK_W'(req_item.block_index);
            free_ff <= free_ff + LINK_W'(1);
         end
         if (pop_done) begin
            head_ff <= rd_ff;
            free_ff <= free_ff - LINK_W'(1);
         end

         if ((res_load || state_ff == S_HOLD) && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (cfg_we) begin
            clr_ff <= '0;
            case (paddr[CSR_AW-1:2])
               REG_BASE:  base_ff      <= pwdata;
               REG_SIZE:  size_ff      <= pwdata[SIZE_W-1:0];
               REG_COUNT: count_cfg_ff <= pwdata[FREE_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // register read
   always_comb begin
      case (paddr[CSR_AW-1:2])
         REG_BASE:  prdata = base_ff;
         REG_SIZE:  prdata = 32'(size_ff);
         REG_COUNT: prdata = 32'(count_cfg_ff);
         default:   prdata = '0;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef NO_ASSERTIONS
   a_free_le_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_CLEAR) |-> (free_ff <= eff_count))
      else $error("free count above pool size");

   a_clear_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR && clr_last && !cfg_we) |=>
         (state_ff == S_IDLE && free_ff == eff_count))
      else $error("pool not rebuilt at end of clearing pass");

   a_pop_lands: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP && !cfg_we) |=> (rsp_valid_ff || state_ff == S_HOLD))
      else $error("allocate result lost");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP) |-> (free_ff != '0))
      else $error("pop from empty pool");

   a_grant_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_item_ff.status == ST_OK ||
         (rsp_item_ff.granted_index == '0 && rsp_item_ff.granted_address == '0)))
      else $error("grant fields set on failed item");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_fixed_block_pool_allocator.sv
// testbench for the fixed block pool allocator: queued stimulus, free-list predictor, result check
module tb_fixed_block_pool_allocator
   import fbpa_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned POOL_DEPTH = 256;
   localparam logic [FREE_W-1:0] NULL_LINK = FREE_W'(POOL_DEPTH);

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_item  = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_item;
   logic                psel      = 1'b0;
   logic                penable   = 1'b0;
   logic                pwrite    = 1'b0;
   logic [CSR_AW-1:0]   paddr     = '0;
   logic [31:0]         pwdata    = '0;
   logic [31:0]         prdata;
   logic                pready;

   fixed_block_pool_allocator #(.MAX_BLOCKS(POOL_DEPTH)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // predictor state
   logic [ADDR_W-1:0] cfg_base  = BASE_RESET;
   logic [SIZE_W-1:0] cfg_size  = SIZE_RESET;
   logic [FREE_W-1:0] cfg_count = COUNT_RESET;
   logic [FREE_W-1:0] link_mem [POOL_DEPTH];
   logic [FREE_W-1:0] pool_head;
   logic [FREE_W-1:0] pool_free;
   logic [FREE_W-1:0] pool_size;

   req_type     request_q [$];
   rsp_type     outcome_q [$];
   int unsigned requests_queued = 0;
   int unsigned requests_taken  = 0;
   int unsigned mismatch_count  = 0;
   logic        req_beat = 1'b0;

   // stimulus-side guess of the free list, used only to pick release indices
   int unsigned guess_free [$];
   int unsigned guess_held [$];
   int unsigned guess_count;

   function automatic void pool_rebuild();
      int i;
      pool_size = (cfg_count > POOL_DEPTH) ? FREE_W'(POOL_DEPTH) : cfg_count;
      for (i = 0; i < POOL_DEPTH; i++) begin
         link_mem[i] = (i + 1 < pool_size) ? FREE_W'(i + 1) : NULL_LINK;
      end
      pool_head = (pool_size > 0) ? '0 : NULL_LINK;
      pool_free = pool_size;
   endfunction

   function automatic rsp_type pool_serve(input req_type item);
      rsp_type r;
      r = '0;
      if (item.command == CMD_ALLOC) begin
         if (pool_free == 0 || pool_head >= POOL_DEPTH) begin
            r.status = ST_EMPTY;
         end else begin
            r.status = ST_OK;
            r.granted_index = pool_head[GIDX_W-1:0];
            r.granted_address = cfg_base + ADDR_W'(pool_head) * ADDR_W'(cfg_size);
            pool_head = link_mem[pool_head[GIDX_W-1:0]];
            pool_free = pool_free - FREE_W'(1);
         end
      end else begin
         // bad index wins over the all-free check
         if (FREE_W'(item.block_index) >= pool_size) begin
            r.status = ST_BAD_IDX;
         end else if (pool_free >= pool_size) begin
            r.status = ST_ALL_FREE;
         end else begin
            r.status = ST_OK;
            link_mem[item.block_index] = pool_head;
            pool_head = FREE_W'(item.block_index);
            pool_free = pool_free + FREE_W'(1);
         end
      end
      r.free_blocks = pool_free;
      return r;
   endfunction

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("Simulation FAILED");
      $finish;
   end

   // sender: bursts of beats with random gaps in between
   int unsigned burst_left = 1;
   int unsigned gap_left   = 0;

   always @(negedge clock) begin
      logic    next_valid;
      req_type next_item;
      next_valid = req_valid;
      next_item  = req_item;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_valid || req_beat) begin
         next_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (request_q.size() > 0) begin
            next_item  = request_q.pop_front();
            next_valid = 1'b1;
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 32);
               gap_left   = ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
      req_valid <= next_valid;
      req_item  <= next_item;
   end

   // receiver: stall mode is redrawn whenever its random timer runs out
   int unsigned stall_mode  = 0;
   int unsigned stall_timer = 0;

   always @(negedge clock) begin
      if (stall_timer == 0) begin
         stall_mode  = $urandom_range(2);
         stall_timer = $urandom_range(16, 80);
      end else begin
         stall_timer--;
      end
      case (stall_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= ($urandom_range(1) == 0);
         default: rsp_ready <= ($urandom_range(3) == 0);
      endcase
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_beat = 1'b0;
      end else begin
         req_beat = req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (outcome_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%t unexpected result beat: status %0d idx %0d addr %h free %0d",
                     $realtime, rsp_item.status, rsp_item.granted_index,
                     rsp_item.granted_address, rsp_item.free_blocks);
            end else begin
               want = outcome_q.pop_front();
               if (rsp_item.status !== want.status ||
                   rsp_item.granted_index !== want.granted_index ||
                   rsp_item.granted_address !== want.granted_address ||
                   rsp_item.free_blocks !== want.free_blocks) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%t mismatch: expected status %0d idx %0d addr %h free %0d, got status %0d idx %0d addr %h free %0d",
                        $realtime, want.status, want.granted_index, want.granted_address,
                        want.free_blocks, rsp_item.status, rsp_item.granted_index,
                        rsp_item.granted_address, rsp_item.free_blocks);
               end
            end
         end
         if (req_beat) begin
            outcome_q.push_back(pool_serve(req_item));
            requests_taken++;
         end
      end
   end

   task automatic csr_write(input logic [1:0] reg_idx, input logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {reg_idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (reg_idx)
         REG_BASE:  cfg_base  = value;
         REG_SIZE:  cfg_size  = value[SIZE_W-1:0];
         REG_COUNT: cfg_count = value[FREE_W-1:0];
         default: ;
      endcase
      pool_rebuild();
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic wait_drained();
      while (!(requests_taken == requests_queued && outcome_q.size() == 0))
         @(posedge clock);
   endtask

   task automatic guess_restart(input int unsigned count);
      int unsigned i;
      guess_count = (count > POOL_DEPTH) ? POOL_DEPTH : count;
      guess_free.delete();
      guess_held.delete();
      for (i = 0; i < guess_count; i++) guess_free.push_back(i);
   endtask

   task automatic reconfigure(input logic [31:0] base, input logic [15:0] size,
                              input logic [8:0] count);
      wait_drained();
      repeat (4) @(posedge clock);
      csr_write(REG_BASE, base);
      csr_write(REG_SIZE, 32'(size));
      csr_write(REG_COUNT, 32'(count));
      guess_restart(32'(count));
   endtask

   task automatic push_item(input logic cmd, input logic [7:0] idx);
      req_type it;
      int k;
      it.command     = cmd;
      it.block_index = idx;
      request_q.push_back(it);
      requests_queued++;
      if (cmd == CMD_ALLOC) begin
         if (guess_free.size() > 0) guess_held.push_back(guess_free.pop_front());
      end else if (32'(idx) < guess_count && guess_free.size() < guess_count) begin
         guess_free.push_front(32'(idx));
         for (k = 0; k < guess_held.size(); k++) begin
            if (guess_held[k] == 32'(idx)) begin
               guess_held.delete(k);
               break;
            end
         end
      end
   endtask

   // mostly alloc/release of held blocks with a drifting bias, some stray releases
   task automatic run_random(input int unsigned n_items);
      int unsigned done;
      int unsigned stretch;
      int unsigned alloc_pct;
      done = 0;
      stretch = 0;
      alloc_pct = 50;
      while (done < n_items) begin
         if (stretch == 0) begin
            stretch = $urandom_range(8, 40);
            case ($urandom_range(2))
               0:       alloc_pct = 15;
               1:       alloc_pct = 50;
               default: alloc_pct = 85;
            endcase
         end
         stretch--;
         if ($urandom_range(99) < 8)
            push_item(CMD_RELEASE, 8'($urandom_range(255)));
         else if ($urandom_range(99) < alloc_pct)
            push_item(CMD_ALLOC, 8'($urandom_range(255)));
         else if (guess_held.size() > 0)
            push_item(CMD_RELEASE, 8'(guess_held[$urandom_range(guess_held.size() - 1)]));
         else
            push_item(CMD_RELEASE, 8'($urandom_range(255)));
         done++;
         // sender holds off once per phase until the pool has answered everything
         if (done == n_items / 2) wait_drained();
      end
   endtask

   initial begin
      logic [31:0] base;
      logic [15:0] size;
      logic [8:0]  count;
      int ph;
      pool_rebuild();
      guess_restart(32'(COUNT_RESET));
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: releases on a full pool, double release, top index
      push_item(CMD_RELEASE, 8'd0);
      push_item(CMD_RELEASE, 8'd255);
      push_item(CMD_ALLOC, 8'd0);
      push_item(CMD_ALLOC, 8'd255);
      push_item(CMD_RELEASE, 8'd0);
      push_item(CMD_RELEASE, 8'd0);
      push_item(CMD_ALLOC, 8'd0);
      push_item(CMD_ALLOC, 8'd0);
      push_item(CMD_RELEASE, 8'd255);
      push_item(CMD_ALLOC, 8'd0);

      // address wrap, empty pool, bad index ahead of all-free
      reconfigure(32'hFFFF_FFFF, 16'hFFFF, 9'd2);
      push_item(CMD_ALLOC, 8'd0);
      push_item(CMD_ALLOC, 8'd0);
      push_item(CMD_ALLOC, 8'd0);
      push_item(CMD_RELEASE, 8'd2);
      push_item(CMD_RELEASE, 8'd255);
      push_item(CMD_RELEASE, 8'd1);
      push_item(CMD_RELEASE, 8'd0);
      push_item(CMD_RELEASE, 8'd1);
      push_item(CMD_RELEASE, 8'd3);

      // zero blocks
      reconfigure(32'h1234_5678, 16'd0, 9'd0);
      push_item(CMD_ALLOC, 8'd0);
      push_item(CMD_RELEASE, 8'd0);

      // count above the pool depth, zero block size
      reconfigure(32'h8000_0000, 16'd0, 9'h1FF);
      push_item(CMD_ALLOC, 8'd0);
      push_item(CMD_ALLOC, 8'd0);

      // single block
      reconfigure(32'd0, 16'd1, 9'd1);
      push_item(CMD_ALLOC, 8'd0);
      push_item(CMD_ALLOC, 8'd0);
      push_item(CMD_RELEASE, 8'd0);
      push_item(CMD_RELEASE, 8'd0);

      for (ph = 0; ph < 10; ph++) begin
         case ($urandom_range(2))
            0:       base = '0;
            1:       base = '1;
            default: base = $urandom;
         endcase
         case ($urandom_range(4))
            0:       size = '0;
            1:       size = 16'd1;
            2:       size = '1;
            default: size = 16'($urandom_range(65535));
         endcase
         if (ph == 3)
            count = 9'd256;
         else if (ph == 6)
            count = 9'($urandom_range(257, 511));
         else
            count = 9'($urandom_range(1, 16));
         reconfigure(base, size, count);
         run_random((count > 16) ? 300 : 135);
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && outcome_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/fbpa_pkg.sv
design/fixed_block_pool_allocator.sv
tb/tb_fixed_block_pool_allocator.sv
